// File: hw/rtl/awmq_pkg.sv
// Shared types, constants and the divider step for the alpha-weighted quad reduce.
// No dependencies.
package awmq_pkg;

  localparam int NUM_CH      = 3;
  localparam int CH_W        = 8;
  localparam int PIX_W       = 32;
  localparam int ALPHA_LSB   = 24;
  localparam int WGT_W       = 8;
  localparam int DVS_W       = WGT_W + 1;
  localparam int REM_W       = CH_W + WGT_W + 1;
  localparam int QUO_W       = CH_W;
  localparam int STEPS       = 2;
  localparam int DIV_STAGES  = QUO_W / STEPS;
  localparam logic [CH_W-1:0] ALPHA_OPAQUE = 8'hFF;
  localparam logic [CH_W-1:0] ALPHA_CLEAR  = 8'h00;

  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [DVS_W-1:0] dvs;
    logic [QUO_W-1:0] quo;
  } awmq_lane_t;

  typedef struct packed {
    awmq_lane_t [NUM_CH-1:0] lane;
    logic                    opaque;
  } awmq_pair_t;

  // index 0: upper pair, index 1: lower pair
  typedef awmq_pair_t [1:0] awmq_quad_t;

  // One restoring step; remainder is shifted left so the divisor window stays fixed.
  function automatic awmq_lane_t div_step(input awmq_lane_t l);
    awmq_lane_t       r;
    logic [REM_W-1:0] win;
    logic [REM_W-1:0] nr;
    logic             ge;
    r   = l;
    win = {l.dvs, {(REM_W-DVS_W-1){1'b0}}, 1'b0} >> 1;
    ge  = (l.rem >= win);
    nr  = ge ? (l.rem - win) : l.rem;
    r.rem = {nr[REM_W-2:0], 1'b0};
    r.quo = {l.quo[QUO_W-2:0], ge};
    return r;
  endfunction

endpackage

// File: hw/rtl/awmq_weigh.sv
// First stage: alpha weights, channel products and divisors for both pairs.
// Depends on awmq_pkg.
module awmq_weigh import awmq_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             src_valid,
  output logic             src_ready,
  input  logic [PIX_W-1:0] top_left,
  input  logic [PIX_W-1:0] top_right,
  input  logic [PIX_W-1:0] bottom_right,
  input  logic [PIX_W-1:0] bottom_left,
  input  logic             dst_ready,
  output logic             dst_valid,
  output awmq_quad_t       dst_quad
);

  awmq_quad_t quad_next;

  function automatic awmq_pair_t weigh(input logic [PIX_W-1:0] p, input logic [PIX_W-1:0] q);
    awmq_pair_t         r;
    logic [WGT_W-1:0]   wp;
    logic [WGT_W-1:0]   wq;
    logic               both_clear;
    logic [2*CH_W-1:0]  mp;
    logic [2*CH_W-1:0]  mq;
    wp = p[ALPHA_LSB +: WGT_W];
    wq = q[ALPHA_LSB +: WGT_W];
    both_clear = (wp == '0) && (wq == '0);
    if (both_clear) begin
      wp = WGT_W'(1);
      wq = WGT_W'(1);
    end
    r.opaque = !both_clear;
    for (int k = 0; k < NUM_CH; k++) begin
      mp = (2*CH_W)'(p[k*CH_W +: CH_W]) * (2*CH_W)'(wp);
      mq = (2*CH_W)'(q[k*CH_W +: CH_W]) * (2*CH_W)'(wq);
      r.lane[k].rem = REM_W'(mp) + REM_W'(mq);
      r.lane[k].dvs = DVS_W'(wp) + DVS_W'(wq);
      r.lane[k].quo = '0;
    end
    return r;
  endfunction

  assign src_ready = !dst_valid || dst_ready;

  always_comb begin
    quad_next[0] = weigh(top_left, top_right);
    quad_next[1] = weigh(bottom_left, bottom_right);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dst_valid <= 1'b0;
    end else if (src_ready) begin
      dst_valid <= src_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (src_ready && src_valid) begin
      dst_quad <= quad_next;
    end
  end

endmodule

// File: hw/rtl/awmq_div_stage.sv
// Divider stage: STEPS quotient bits for all six channel lanes.
// Depends on awmq_pkg.
module awmq_div_stage import awmq_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       src_valid,
  output logic       src_ready,
  input  awmq_quad_t src_quad,
  input  logic       dst_ready,
  output logic       dst_valid,
  output awmq_quad_t dst_quad
);

  awmq_quad_t quad_next;

  assign src_ready = !dst_valid || dst_ready;

  always_comb begin
    quad_next = src_quad;
    for (int p = 0; p < 2; p++) begin
      for (int k = 0; k < NUM_CH; k++) begin
        for (int s = 0; s < STEPS; s++) begin
          quad_next[p].lane[k] = div_step(quad_next[p].lane[k]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dst_valid <= 1'b0;
    end else if (src_ready) begin
      dst_valid <= src_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (src_ready && src_valid) begin
      dst_quad <= quad_next;
    end
  end

endmodule

// File: hw/rtl/awmq_merge.sv
// Final stage: blends the two pair results (alphas only 0 or 255) into the output pixel.
// Depends on awmq_pkg.
module awmq_merge import awmq_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             src_valid,
  output logic             src_ready,
  input  awmq_quad_t       src_quad,
  input  logic             dst_ready,
  output logic             dst_valid,
  output logic [PIX_W-1:0] pixel
);

  logic [PIX_W-1:0] pixel_next;
  logic [CH_W:0]    mean;
  logic             up_op;
  logic             lo_op;

  assign src_ready = !dst_valid || dst_ready;
  assign up_op     = src_quad[0].opaque;
  assign lo_op     = src_quad[1].opaque;

  always_comb begin
    pixel_next = '0;
    mean       = '0;
    pixel_next[ALPHA_LSB +: CH_W] = (up_op || lo_op) ? ALPHA_OPAQUE : ALPHA_CLEAR;
    for (int k = 0; k < NUM_CH; k++) begin
      mean = {1'b0, src_quad[0].lane[k].quo} + {1'b0, src_quad[1].lane[k].quo};
      if (up_op && !lo_op) begin
        pixel_next[k*CH_W +: CH_W] = src_quad[0].lane[k].quo;
      end else if (lo_op && !up_op) begin
        pixel_next[k*CH_W +: CH_W] = src_quad[1].lane[k].quo;
      end else begin
        pixel_next[k*CH_W +: CH_W] = mean[CH_W:1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dst_valid <= 1'b0;
    end else if (src_ready) begin
      dst_valid <= src_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (src_ready && src_valid) begin
      pixel <= pixel_next;
    end
  end

endmodule

// File: hw/rtl/alpha_weighted_mip_quad_reduce.sv
// Alpha-weighted 2x2 mipmap reduce: one quad in, one pixel out.
// Registered pipeline: weighting, four 2-bit divider stages, merge.
// Throughput one quad per cycle while pixel_stall is low; each stage holds while stalled and fills bubbles.
// Synchronous active-high reset clears all valid bits; data registers are not reset.
// Depends on awmq_pkg, awmq_weigh, awmq_div_stage, awmq_merge.
module alpha_weighted_mip_quad_reduce import awmq_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             quad_valid,
  output logic             quad_stall,
  input  logic [PIX_W-1:0] top_left,
  input  logic [PIX_W-1:0] top_right,
  input  logic [PIX_W-1:0] bottom_right,
  input  logic [PIX_W-1:0] bottom_left,
  output logic             pixel_valid,
  input  logic             pixel_stall,
  output logic [PIX_W-1:0] reduced_pixel
);

  logic       vld [DIV_STAGES+1];
  logic       rdy [DIV_STAGES+2];
  awmq_quad_t quad [DIV_STAGES+1];

  assign quad_stall = !rdy[0];

  awmq_weigh u_weigh (
    .clk          (clk),
    .rst          (rst),
    .src_valid    (quad_valid),
    .src_ready    (rdy[0]),
    .top_left     (top_left),
    .top_right    (top_right),
    .bottom_right (bottom_right),
    .bottom_left  (bottom_left),
    .dst_ready    (rdy[1]),
    .dst_valid    (vld[0]),
    .dst_quad     (quad[0])
  );

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    awmq_div_stage u_div (
      .clk       (clk),
      .rst       (rst),
      .src_valid (vld[g]),
      .src_ready (rdy[g+1]),
      .src_quad  (quad[g]),
      .dst_ready (rdy[g+2]),
      .dst_valid (vld[g+1]),
      .dst_quad  (quad[g+1])
    );
  end

  awmq_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .src_valid (vld[DIV_STAGES]),
    .src_ready (rdy[DIV_STAGES+1]),
    .src_quad  (quad[DIV_STAGES]),
    .dst_ready (!pixel_stall),
    .dst_valid (pixel_valid),
    .pixel     (reduced_pixel)
  );

endmodule

// File: tb/alpha_weighted_mip_quad_reduce_test.sv
// Testbench for alpha_weighted_mip_quad_reduce: directed and random quads, random idling both sides.
// Holds a small scoreboard class with its own alpha-weighted blend predictor.
// Depends on awmq_pkg and the alpha_weighted_mip_quad_reduce RTL.
class quad_scoreboard;
  logic [awmq_pkg::PIX_W-1:0] pending[$];
  int errors = 0;

  function automatic logic [awmq_pkg::PIX_W-1:0] blend_pair(
    input logic [awmq_pkg::PIX_W-1:0] p,
    input logic [awmq_pkg::PIX_W-1:0] q
  );
    int unsigned wp;
    int unsigned wq;
    int unsigned sum;
    int unsigned ch;
    int c;
    logic [awmq_pkg::PIX_W-1:0] r;
    wp = 32'(p[awmq_pkg::ALPHA_LSB +: awmq_pkg::CH_W]);
    wq = 32'(q[awmq_pkg::ALPHA_LSB +: awmq_pkg::CH_W]);
    r = '0;
    r[awmq_pkg::ALPHA_LSB +: awmq_pkg::CH_W] = awmq_pkg::ALPHA_OPAQUE;
    // both transparent: plain mean, alpha cleared
    if (wp + wq == 0) begin
      wp = 1;
      wq = 1;
      r[awmq_pkg::ALPHA_LSB +: awmq_pkg::CH_W] = awmq_pkg::ALPHA_CLEAR;
    end
    sum = wp + wq;
    for (c = 0; c < awmq_pkg::NUM_CH; c++) begin
      ch = (32'(p[c*awmq_pkg::CH_W +: awmq_pkg::CH_W]) * wp
          + 32'(q[c*awmq_pkg::CH_W +: awmq_pkg::CH_W]) * wq) / sum;
      r[c*awmq_pkg::CH_W +: awmq_pkg::CH_W] = ch[awmq_pkg::CH_W-1:0];
    end
    return r;
  endfunction

  function void note_quad(
    input logic [awmq_pkg::PIX_W-1:0] tl,
    input logic [awmq_pkg::PIX_W-1:0] tr,
    input logic [awmq_pkg::PIX_W-1:0] br,
    input logic [awmq_pkg::PIX_W-1:0] bl
  );
    pending = {pending, blend_pair(blend_pair(tl, tr), blend_pair(bl, br))};
  endfunction

  function void check_pixel(input logic [awmq_pkg::PIX_W-1:0] got);
    logic [awmq_pkg::PIX_W-1:0] want;
    if (pending.size() == 0) begin
      $error("reduced_pixel: expected none, actual %h", got);
      errors++;
    end else begin
      want = pending.pop_front();
      if (got !== want) begin
        $error("reduced_pixel: expected %h, actual %h", want, got);
        errors++;
      end
    end
  endfunction
endclass

module alpha_weighted_mip_quad_reduce_test import awmq_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             quad_valid = 1'b0;
  logic             quad_stall;
  logic [PIX_W-1:0] top_left = '0;
  logic [PIX_W-1:0] top_right = '0;
  logic [PIX_W-1:0] bottom_right = '0;
  logic [PIX_W-1:0] bottom_left = '0;
  logic             pixel_valid;
  logic             pixel_stall = 1'b0;
  logic [PIX_W-1:0] reduced_pixel;

  quad_scoreboard sb = new();
  int sent_count = 0;
  int got_count = 0;
  int hold_left = 0;

  alpha_weighted_mip_quad_reduce dut (
    .clk          (clk),
    .rst          (rst),
    .quad_valid   (quad_valid),
    .quad_stall   (quad_stall),
    .top_left     (top_left),
    .top_right    (top_right),
    .bottom_right (bottom_right),
    .bottom_left  (bottom_left),
    .pixel_valid  (pixel_valid),
    .pixel_stall  (pixel_stall),
    .reduced_pixel(reduced_pixel)
  );

  always #6 clk = ~clk;

  function automatic int draw_wait(input bit calm);
    if (calm) return 0;
    return ($urandom_range(0, 1) == 0) ? $urandom_range(0, 14) : $urandom_range(0, 1);
  endfunction

  function automatic logic [PIX_W-1:0] rand_pixel();
    logic [PIX_W-1:0] p;
    p = $urandom;
    case ($urandom_range(0, 5))
      0: p[ALPHA_LSB +: CH_W] = ALPHA_CLEAR;
      1: p[ALPHA_LSB +: CH_W] = ALPHA_OPAQUE;
      2: p[ALPHA_LSB +: CH_W] = 8'h01;
      default: ;
    endcase
    if ($urandom_range(0, 7) == 0) p[ALPHA_LSB-1:0] = $urandom_range(0, 1) ? '1 : '0;
    return p;
  endfunction

  // Receiver: stall for a drawn number of cycles after each accepted pixel
  always @(posedge clk) begin
    if (!rst && pixel_valid && !pixel_stall) begin
      sb.check_pixel(reduced_pixel);
      got_count++;
      hold_left = draw_wait((got_count / 70) % 4 == 3);
      pixel_stall <= (hold_left != 0);
    end else if (pixel_stall) begin
      if (hold_left > 0) hold_left--;
      pixel_stall <= (hold_left != 0);
    end
  end

  task automatic send_quad(
    input logic [PIX_W-1:0] tl,
    input logic [PIX_W-1:0] tr,
    input logic [PIX_W-1:0] br,
    input logic [PIX_W-1:0] bl
  );
    int gap;
    gap = draw_wait((sent_count / 50) % 5 == 2);
    if (gap > 0) begin
      quad_valid   <= 1'b0;
      top_left     <= $urandom;
      top_right    <= $urandom;
      bottom_right <= $urandom;
      bottom_left  <= $urandom;
      repeat (gap) @(posedge clk);
    end
    quad_valid   <= 1'b1;
    top_left     <= tl;
    top_right    <= tr;
    bottom_right <= br;
    bottom_left  <= bl;
    do @(posedge clk); while (quad_stall);
    sb.note_quad(tl, tr, br, bl);
    sent_count++;
  endtask

  initial begin
    logic [PIX_W-1:0] q[4];
    int n;
    int k;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed requests
    send_quad('0, '0, '0, '0);
    send_quad('1, '1, '1, '1);
    send_quad(32'h00FFFFFF, 32'h00000000, 32'h00FFFFFF, 32'h00000000);
    send_quad(32'h00FF00FF, 32'h0000FF01, 32'h00123456, 32'h00FEDCBA);
    send_quad(32'h00FFFFFF, 32'h00FFFFFE, 32'hFF123456, 32'h01ABCDEF);
    send_quad(32'h80AABBCC, 32'h7F332211, 32'h00FFFFFF, 32'h00FFFFFF);
    send_quad(32'h00FFFFFF, 32'hFF000000, 32'h00000000, 32'hFFFFFFFF);
    send_quad(32'h01FFFFFF, 32'hFF000000, 32'hFF000000, 32'h01FFFFFF);
    send_quad(32'hFFFFFFFF, 32'h01000000, 32'h01000000, 32'hFFFFFFFF);
    send_quad(32'h01FFFFFF, 32'h01FFFFFF, 32'h01FFFFFF, 32'h01FFFFFF);
    send_quad(32'hAAAAAAAA, 32'h55555555, 32'hAAAAAAAA, 32'h55555555);
    send_quad(32'h55555555, 32'hAAAAAAAA, 32'h55555555, 32'hAAAAAAAA);
    send_quad(32'hFF102030, 32'h00FFFFFF, 32'h00FFFFFF, 32'h00FFFFFF);
    send_quad(32'h00FFFFFF, 32'hFF102030, 32'h00FFFFFF, 32'h00FFFFFF);
    send_quad(32'h00FFFFFF, 32'h00FFFFFF, 32'hFF102030, 32'h00FFFFFF);
    send_quad(32'h00FFFFFF, 32'h00FFFFFF, 32'h00FFFFFF, 32'hFF102030);
    send_quad(32'h00000000, 32'h00000001, 32'hFE00FF00, 32'h02FF00FF);

    // random requests
    for (n = 0; n < 1300; n++) begin
      for (k = 0; k < 4; k++) q[k] = rand_pixel();
      if ($urandom_range(0, 19) == 0)
        for (k = 0; k < 4; k++) q[k][ALPHA_LSB +: CH_W] = ALPHA_CLEAR;
      send_quad(q[0], q[1], q[2], q[3]);
    end
    quad_valid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("alpha_weighted_mip_quad_reduce: match");
    end else begin
      $display("alpha_weighted_mip_quad_reduce: mismatch");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("alpha_weighted_mip_quad_reduce: mismatch");
    $finish;
  end
endmodule

// File: alpha_weighted_mip_quad_reduce.f
hw/rtl/awmq_pkg.sv
hw/rtl/awmq_weigh.sv
hw/rtl/awmq_div_stage.sv
hw/rtl/awmq_merge.sv
hw/rtl/alpha_weighted_mip_quad_reduce.sv
tb/alpha_weighted_mip_quad_reduce_test.sv
